// ===== design/assert_macros.svh =====
// Assertion macros shared by the console writer RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define TCW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Used by the channel interfaces and the top level; no dependencies.
package tcw_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Fixed field widths of the channels.
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int COL_W_PORT = 7;
    localparam int ROW_W_PORT = 5;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COLOR_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT_AT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

    // Character codes and the reset cell (white-on-black space).
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CELL_W-1:0] CELL_RESET   = 16'h0F20;
    localparam logic [COLOR_W-1:0] FG_RESET    = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET    = 4'h0;

endpackage

// ===== design/tcw_ifs.sv =====
// Valid/ready channel interfaces of the text console writer.
// Depends on tcw_pkg for the field widths.

// Request channel: one operation on the screen.
interface tcw_req_if import tcw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       op;
    logic [CHAR_W-1:0]     char_code;
    logic [COL_W_PORT-1:0] col;
    logic [ROW_W_PORT-1:0] row;

    modport source (output valid, op, char_code, col, row, input ready);
    modport sink   (input valid, op, char_code, col, row, output ready);
endinterface

// Response channel: the cell read and the cursor after the operation.
interface tcw_rsp_if import tcw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CELL_W-1:0]     cell_value;
    logic [COL_W_PORT-1:0] cursor_col;
    logic [ROW_W_PORT-1:0] cursor_row;

    modport source (output valid, cell_value, cursor_col, cursor_row, input ready);
    modport sink   (input valid, cell_value, cursor_col, cursor_row, output ready);
endinterface

// Configuration write channel.
interface tcw_cfg_if import tcw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/tcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/text_console_writer_unit.sv =====
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (color byte over character
// byte) in one RAM with a cursor. After reset the block sweeps every cell to a white-on-black
// space, one cell a cycle, and accepts no request meanwhile; configuration writes are taken
// at any time. Afterwards one request is handled at a time: a put, put-at or unused op goes
// through ST_POST to the response register, a read through ST_READ and then ST_POST. A put
// or newline that runs past the last row scrolls through the single RAM: one cell copied per
// cycle, then the bottom row is blanked. Depends on tcw_pkg, tcw_ifs, tcw_ram and
// assert_macros.svh.
`include "assert_macros.svh"

module text_console_writer_unit import tcw_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic      clk,
    input  logic      rst_n,
    tcw_req_if.sink   req,
    tcw_rsp_if.source rsp,
    tcw_cfg_if.sink   cfg
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_A  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [COL_W:0]    COL_END   = (COL_W + 1)'(COLUMNS);
    localparam logic [RW-1:0]     ROW_LAST  = RW'(ROWS - 1);

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_BLANK  = 3'd4;
    localparam logic [2:0] ST_POST   = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [RW-1:0]      cur_row_reg, cur_row_next;
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic               copy_pend_reg, copy_pend_next;
    logic [ADDR_W-1:0]  copy_dst_reg, copy_dst_next;
    logic               read_ok_reg, read_ok_next;
    logic [CELL_W-1:0]  pend_cell_reg, pend_cell_next;
    logic               out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]  out_cell_reg, out_cell_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [RW-1:0]      out_row_reg, out_row_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    logic [ADDR_W-1:0]  pos_addr;
    logic [ADDR_W-1:0]  cur_addr;
    logic               pos_inside;
    logic [COL_W:0]     col_inc;
    logic [CELL_W-1:0]  blank_cell;
    logic [CELL_W-1:0]  put_cell;

    // Screen memory.
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Address arithmetic and cell formatting.
    assign pos_addr   = ADDR_W'(req.row) * COLS_A + ADDR_W'(req.col);
    assign cur_addr   = ADDR_W'(cur_row_reg) * COLS_A + ADDR_W'(cur_col_reg);
    assign pos_inside = (32'(req.col) < COLUMNS) && (32'(req.row) < ROWS);
    assign col_inc    = {1'b0, cur_col_reg} + (COL_W + 1)'(1);
    assign blank_cell = {bg_reg, fg_reg, SPACE_CODE};
    assign put_cell   = {bg_reg, fg_reg, req.char_code};

    // Channel outputs.
    assign req.ready      = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_value = out_cell_reg;
    assign rsp.cursor_col = COL_W_PORT'(out_col_reg);
    assign rsp.cursor_row = ROW_W_PORT'(out_row_reg);

    // Sequencer, cursor and memory port control.
    always_comb
    begin
        logic line_go;

        state_next     = state_reg;
        idx_next       = idx_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        copy_pend_next = 1'b0;
        copy_dst_next  = copy_dst_reg;
        read_ok_next   = read_ok_reg;
        pend_cell_next = pend_cell_reg;
        out_valid_next = out_valid_reg;
        out_cell_next  = out_cell_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = blank_cell;
        ram_raddr      = idx_reg;
        line_go        = 1'b0;

        // Configuration transactions.
        if (cfg.valid)
        begin
            if (cfg.index == REG_FG)
            begin
                fg_next = cfg.data;
            end
            else if (cfg.index == REG_BG)
            begin
                bg_next = cfg.data;
            end
        end

        // Response register drains independently of the sequencer.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = CELL_RESET;
                if (idx_reg == LAST_A)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    pend_cell_next = '0;
                    state_next     = ST_POST;
                    unique case (req.op)
                        OP_PUT:
                        begin
                            if (req.char_code == NEWLINE_CODE)
                            begin
                                cur_col_next = '0;
                                line_go      = 1'b1;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cur_addr;
                                ram_wdata = put_cell;
                                if (col_inc == COL_END)
                                begin
                                    cur_col_next = '0;
                                    line_go      = 1'b1;
                                end
                                else
                                begin
                                    cur_col_next = col_inc[COL_W-1:0];
                                end
                            end
                            // Next line: step down, or scroll at the bottom row.
                            if (line_go)
                            begin
                                if (cur_row_reg != ROW_LAST)
                                begin
                                    cur_row_next = cur_row_reg + RW'(1);
                                end
                                else
                                begin
                                    idx_next   = COLS_A;
                                    state_next = ST_SCROLL;
                                end
                            end
                        end
                        OP_PUT_AT:
                        begin
                            if (pos_inside)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_addr;
                                ram_wdata = put_cell;
                            end
                        end
                        OP_READ:
                        begin
                            ram_raddr    = pos_addr;
                            read_ok_next = pos_inside;
                            state_next   = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_POST;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                pend_cell_next = read_ok_reg ? ram_rdata : '0;
                state_next     = ST_POST;
            end

            // Read one row ahead; the copy lands in the following cycle.
            ST_SCROLL:
            begin
                copy_pend_next = 1'b1;
                copy_dst_next  = idx_reg - COLS_A;
                if (idx_reg == LAST_A)
                begin
                    idx_next   = BOTTOM_A;
                    state_next = ST_BLANK;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end

            // Blank the bottom row once the last copy has landed.
            ST_BLANK:
            begin
                if (!copy_pend_reg)
                begin
                    ram_we = 1'b1;
                    if (idx_reg == LAST_A)
                    begin
                        idx_next   = '0;
                        state_next = ST_POST;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end

            ST_POST:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = pend_cell_reg;
                    out_col_next   = cur_col_reg;
                    out_row_next   = cur_row_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A pending scroll copy owns the write port.
        if (copy_pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = copy_dst_reg;
            ram_wdata = ram_rdata;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            fg_reg        <= FG_RESET;
            bg_reg        <= BG_RESET;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            copy_pend_reg <= copy_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        copy_dst_reg  <= copy_dst_next;
        read_ok_reg   <= read_ok_next;
        pend_cell_reg <= pend_cell_next;
        out_cell_reg  <= out_cell_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
    end

    // The cursor never leaves the screen.
    `TCW_ASSERT_ALWAYS(a_cursor_range,
        (32'(cur_col_reg) < COLUMNS) && (32'(cur_row_reg) < ROWS), "cursor out of range")
    // Writes always address a cell that exists.
    `TCW_ASSERT_IMPLY(a_write_range, ram_we, 32'(ram_waddr) < CELLS, "write beyond screen")
    // Scroll copies are only in flight while scrolling or draining into the blank pass.
    `TCW_ASSERT_IMPLY(a_copy_window, copy_pend_reg,
        state_reg == ST_SCROLL || state_reg == ST_BLANK, "stray scroll copy")
    // A scroll only runs with the cursor on the bottom row.
    `TCW_ASSERT_IMPLY(a_scroll_row, state_reg == ST_SCROLL || state_reg == ST_BLANK,
        cur_row_reg == ROW_LAST, "scroll with cursor above bottom row")

endmodule
